/* rtl/rbpf_pkg.sv */
// Shared types and constants for the refcounted byte pipe FIFO.
// Used by rbpf_ring, rbpf_ctrl and refcounted_byte_pipe_fifo; depends on nothing.
package rbpf_pkg;

    // Default geometry of the pipe.
    localparam int RING_DEPTH_DEF = 4096;
    localparam int REF_MAX_DEF    = 255;

    // Fixed widths of the result fields.
    localparam int DATA_W  = 8;
    localparam int MOVED_W = 13;
    localparam int COUNT_W = 8;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;

    // The per-request byte counter saturates here.
    localparam logic [MOVED_W-1:0] MOVED_MAX = {MOVED_W{1'b1}};

    // Command codes carried on the input tuser.
    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE   = 3'd0,
        CMD_WRITE    = 3'd1,
        CMD_READ     = 3'd2,
        CMD_ADD_RD   = 3'd3,
        CMD_ADD_WR   = 3'd4,
        CMD_CLOSE_RD = 3'd5,
        CMD_CLOSE_WR = 3'd6
    } t_cmd;

    // Result status carried on the output tuser.
    typedef enum logic [STAT_W-1:0] {
        ST_DONE    = 2'd0,
        ST_REFUSED = 2'd1,
        ST_NO_PIPE = 2'd2
    } t_status;

    // Everything of one result except the byte read from the ring.
    typedef struct packed {
        t_status              status;
        logic [MOVED_W-1:0]   moved;
        logic [MOVED_W-1:0]   fill;
        logic [COUNT_W-1:0]   rd_cnt;
        logic [COUNT_W-1:0]   wr_cnt;
        logic                 ring_full;
        logic                 has_data;
        logic                 released;
        logic                 rd_ok;
    } t_result;

    // Access request to the ring memory.
    typedef struct packed {
        logic we;
        logic re;
    } t_ring_ctl;

endpackage

/* rtl/rbpf_ring.sv */
// Byte ring storage: one synchronous memory with a registered read port.
// Depends on rbpf_pkg for the ring access request type.
module rbpf_ring #(
    parameter int RING_DEPTH = rbpf_pkg::RING_DEPTH_DEF,
    parameter int AW         = $clog2(RING_DEPTH)
) (
    input  logic                      i_clk,
    input  rbpf_pkg::t_ring_ctl       i_ctl,
    input  logic [AW-1:0]             i_addr,
    input  logic [rbpf_pkg::DATA_W-1:0] i_wdata,
    output logic [rbpf_pkg::DATA_W-1:0] o_rdata
);
    import rbpf_pkg::*;

    logic [DATA_W-1:0] r_mem [RING_DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/rbpf_ctrl.sv */
// Pipe control: positions, reference counts and request state, updated once per item.
// Depends on rbpf_pkg; drives the access request of rbpf_ring.
module rbpf_ctrl #(
    parameter int RING_DEPTH = rbpf_pkg::RING_DEPTH_DEF,
    parameter int REF_MAX    = rbpf_pkg::REF_MAX_DEF,
    parameter int AW         = $clog2(RING_DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [rbpf_pkg::CMD_W-1:0]  i_cmd,
    input  logic                        i_last,
    output rbpf_pkg::t_result           o_res,
    output rbpf_pkg::t_ring_ctl         o_ring_ctl,
    output logic [AW-1:0]               o_addr
);
    import rbpf_pkg::*;

    localparam int PW = AW + 1;
    localparam int RW = (REF_MAX < 2) ? 1 : $clog2(REF_MAX + 1);

    logic [PW-1:0]      r_wp, n_wp;
    logic [PW-1:0]      r_rp, n_rp;
    logic [RW-1:0]      r_rd_refs, n_rd_refs;
    logic [RW-1:0]      r_wr_refs, n_wr_refs;
    logic               r_live, n_live;
    logic [MOVED_W-1:0] r_moved, n_moved;
    logic               r_stopped, n_stopped;

    logic [PW-1:0]      fill_now;
    logic [PW-1:0]      fill_after;
    logic               byte_ok;

    assign fill_now = r_wp - r_rp;

    // Next state and result of the current command.
    always_comb begin
        n_wp         = r_wp;
        n_rp         = r_rp;
        n_rd_refs    = r_rd_refs;
        n_wr_refs    = r_wr_refs;
        n_live       = r_live;
        n_moved      = r_moved;
        n_stopped    = r_stopped;
        o_res        = '0;
        o_res.status = ST_DONE;
        o_ring_ctl   = '0;
        o_addr       = r_wp[AW-1:0];
        byte_ok      = 1'b0;

        if (t_cmd'(i_cmd) == CMD_CREATE) begin
            n_wp      = '0;
            n_rp      = '0;
            n_rd_refs = '0;
            n_wr_refs = '0;
            n_moved   = '0;
            n_stopped = 1'b0;
            n_live    = 1'b1;
        end else if (!r_live) begin
            o_res.status = ST_NO_PIPE;
        end else begin
            case (t_cmd'(i_cmd))
                CMD_WRITE, CMD_READ: begin
                    if (t_cmd'(i_cmd) == CMD_WRITE) begin
                        byte_ok = !r_stopped && (fill_now != PW'(RING_DEPTH));
                    end else begin
                        byte_ok = !r_stopped && (fill_now != '0);
                        o_addr  = r_rp[AW-1:0];
                    end
                    if (byte_ok) begin
                        if (t_cmd'(i_cmd) == CMD_WRITE) begin
                            o_ring_ctl.we = 1'b1;
                            n_wp          = r_wp + 1'b1;
                        end else begin
                            o_ring_ctl.re = 1'b1;
                            o_res.rd_ok   = 1'b1;
                            n_rp          = r_rp + 1'b1;
                        end
                        if (r_moved != MOVED_MAX) begin
                            n_moved = r_moved + 1'b1;
                        end
                    end else begin
                        o_res.status = ST_REFUSED;
                        n_stopped    = 1'b1;
                    end
                    o_res.moved = n_moved;
                    // The end of a request clears its state, moved or refused.
                    if (i_last) begin
                        n_moved   = '0;
                        n_stopped = 1'b0;
                    end
                end
                CMD_ADD_RD: begin
                    if (r_rd_refs >= RW'(REF_MAX)) begin
                        o_res.status = ST_REFUSED;
                    end else begin
                        n_rd_refs = r_rd_refs + 1'b1;
                    end
                end
                CMD_ADD_WR: begin
                    if (r_wr_refs >= RW'(REF_MAX)) begin
                        o_res.status = ST_REFUSED;
                    end else begin
                        n_wr_refs = r_wr_refs + 1'b1;
                    end
                end
                CMD_CLOSE_RD, CMD_CLOSE_WR: begin
                    if (t_cmd'(i_cmd) == CMD_CLOSE_RD) begin
                        if (r_rd_refs == '0) begin
                            o_res.status = ST_REFUSED;
                        end else begin
                            n_rd_refs = r_rd_refs - 1'b1;
                        end
                    end else begin
                        if (r_wr_refs == '0) begin
                            o_res.status = ST_REFUSED;
                        end else begin
                            n_wr_refs = r_wr_refs - 1'b1;
                        end
                    end
                    // Dropping the last reference of both ends frees the pipe.
                    if (o_res.status == ST_DONE && n_rd_refs == '0 && n_wr_refs == '0) begin
                        o_res.released = 1'b1;
                        n_wp           = '0;
                        n_rp           = '0;
                        n_moved        = '0;
                        n_stopped      = 1'b0;
                        n_live         = 1'b0;
                    end
                end
                default: begin
                    o_res.status = ST_REFUSED;
                end
            endcase
        end

        // Status fields after the step.
        fill_after      = n_live ? (n_wp - n_rp) : '0;
        o_res.fill      = MOVED_W'(fill_after);
        o_res.ring_full = (fill_after == PW'(RING_DEPTH));
        o_res.has_data  = (fill_after != '0);
        o_res.rd_cnt    = n_live ? COUNT_W'(n_rd_refs) : '0;
        o_res.wr_cnt    = n_live ? COUNT_W'(n_wr_refs) : '0;

        // Nothing commits without an accepted item.
        if (!i_fire) begin
            o_ring_ctl = '0;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_rp      <= '0;
            r_rd_refs <= '0;
            r_wr_refs <= '0;
            r_live    <= 1'b0;
            r_moved   <= '0;
            r_stopped <= 1'b0;
        end else if (i_fire) begin
            r_wp      <= n_wp;
            r_rp      <= n_rp;
            r_rd_refs <= n_rd_refs;
            r_wr_refs <= n_wr_refs;
            r_live    <= n_live;
            r_moved   <= n_moved;
            r_stopped <= n_stopped;
        end
    end

endmodule

/* rtl/refcounted_byte_pipe_fifo.sv */
// Top level of the refcounted byte pipe FIFO: stream ports, result pipeline, assertions.
// Depends on rbpf_pkg, rbpf_ctrl and rbpf_ring.
//
// Each input item is one command (create, write byte, read byte, add or close a reader or
// writer reference) and yields exactly one result item. An accepted item passes through
// stage one, which waits for the registered read port of the ring memory, and then the
// output register, which drives the result. With the output side ready the block takes
// one item every cycle; a stalled result holds in the output register while one more
// item is accepted into the stage behind it. The ring store needs no clearing after reset,
// so the block is ready as soon as reset is released. RING_DEPTH must be a power of two.
module refcounted_byte_pipe_fifo #(
    parameter int RING_DEPTH = rbpf_pkg::RING_DEPTH_DEF,
    parameter int REF_MAX    = rbpf_pkg::REF_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] data_in
    input  logic [rbpf_pkg::CMD_W-1:0]    s_axis_tuser,  // [2:0] command
    input  logic                          s_axis_tlast,  // end_of_request
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] data_out, [20:8] moved_count, [33:21] fill_level, [41:34] reader_count,
    // [49:42] writer_count, [50] ring_full, [51] has_data, [52] released, [55:53] zero
    output logic [55:0]                   m_axis_tdata,
    output logic [rbpf_pkg::STAT_W-1:0]   m_axis_tuser   // [1:0] status
);
    import rbpf_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);

    logic              fire;
    logic              s1_move;
    t_result           ctl_res;
    t_ring_ctl         ring_ctl;
    logic [AW-1:0]     ring_addr;
    logic [DATA_W-1:0] ring_rdata;

    logic              r_s1_valid;
    t_result           r_s1_res;
    logic              r_out_valid;
    t_result           r_out_res;
    logic [DATA_W-1:0] r_out_data;

    // Handshake: the stage behind the output register frees as it moves on.
    assign s1_move       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_move;
    assign fire          = s_axis_tvalid && s_axis_tready;

    rbpf_ctrl #(
        .RING_DEPTH (RING_DEPTH),
        .REF_MAX    (REF_MAX),
        .AW         (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_cmd      (s_axis_tuser),
        .i_last     (s_axis_tlast),
        .o_res      (ctl_res),
        .o_ring_ctl (ring_ctl),
        .o_addr     (ring_addr)
    );

    rbpf_ring #(
        .RING_DEPTH (RING_DEPTH),
        .AW         (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_ctl   (ring_ctl),
        .i_addr  (ring_addr),
        .i_wdata (s_axis_tdata),
        .o_rdata (ring_rdata)
    );

    // Stage one waits for the ring read; the output register holds the finished item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_s1_res <= ctl_res;
        end
        if (s1_move) begin
            r_out_res  <= r_s1_res;
            r_out_data <= r_s1_res.rd_ok ? ring_rdata : '0;
        end
    end

    // Output packing.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_res.status;
    assign m_axis_tdata  = {3'b000, r_out_res.released, r_out_res.has_data,
                            r_out_res.ring_full, r_out_res.wr_cnt, r_out_res.rd_cnt,
                            r_out_res.fill, r_out_res.moved, r_out_data};

    // An accepted item always occupies stage one in the next cycle.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_s1_valid)
        else $error("accepted item did not reach stage one");

    // Without a live pipe the result carries nothing but its status.
    a_no_pipe_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_NO_PIPE) |-> (m_axis_tdata == '0))
        else $error("no-pipe result carries data");

    // A byte comes out only with a completed read.
    a_data_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_DONE) |-> (m_axis_tdata[7:0] == '0))
        else $error("data byte on a refused result");

    // A release leaves an empty pipe with no references.
    a_release_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[52]) |->
            (m_axis_tdata[51:21] == '0 && m_axis_tuser == ST_DONE))
        else $error("release left state behind");

endmodule
